@@ src/pst_pkg.sv @@
package pst_pkg;

  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned INDEX_W = 6;
  localparam int unsigned TIME_W  = 21;
  localparam int unsigned AVG_W   = 29;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [BURST_W-1:0] burst_time;
    logic [PRIO_W-1:0]  priority_req;
    logic               last;
    logic               keep;
  } pst_job_t;

  typedef enum logic [2:0] {
    BK_LOAD,
    BK_SCAN,
    BK_EMIT,
    BK_DIV,
    BK_FIN
  } pst_back_state_e;

endpackage

@@ src/pst_if.sv @@
interface pst_job_if import pst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_time;
  logic [PRIO_W-1:0]  priority_req;
  logic               last;

  modport source (output valid, burst_time, priority_req, last, input ready);
  modport sink (input valid, burst_time, priority_req, last, output ready);
endinterface

interface pst_res_if import pst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] job_index;
  logic [BURST_W-1:0] job_burst;
  logic [PRIO_W-1:0]  job_priority;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround_time;
  logic [AVG_W-1:0]   avg_wait_q8;
  logic [AVG_W-1:0]   avg_turnaround_q8;
  logic               final_res;
  logic               overflow;

  modport source (
    output valid, job_index, job_burst, job_priority, wait_time, turnaround_time,
           avg_wait_q8, avg_turnaround_q8, final_res, overflow,
    input  ready
  );
  modport sink (
    input  valid, job_index, job_burst, job_priority, wait_time, turnaround_time,
           avg_wait_q8, avg_turnaround_q8, final_res, overflow,
    output ready
  );
endinterface

@@ src/pst_front.sv @@
module pst_front import pst_pkg::*; #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pst_job_if.sink  job_i,
  output logic     push_valid_o,
  output pst_job_t push_data_o,
  input  logic     push_ready_i
);

  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             keep;
  logic             fire;

  // A request is kept while the set still has room; beyond that it is dropped.
  assign keep = (cnt_q < CNT_W'(MAX_JOBS));
  assign fire = job_i.valid && push_ready_i;

  assign job_i.ready  = push_ready_i;
  assign push_valid_o = job_i.valid;
  assign push_data_o  = '{burst_time:   job_i.burst_time,
                          priority_req: job_i.priority_req,
                          last:         job_i.last,
                          keep:         keep};

  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (job_i.last) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/pst_queue.sv @@
module pst_queue import pst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  input  pst_job_t push_data_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output pst_job_t pop_data_o,
  input  logic     pop_ready_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  pst_job_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              push, pop;

  assign push_ready_o = (fill_q != FILL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

@@ src/pst_div.sv @@
module pst_div #(
  parameter int unsigned DVD_W = 36,
  parameter int unsigned DVS_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] acc_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh, diff;
  logic             ge;

  // Restoring division: one quotient bit per cycle, shifted into the dividend word.
  assign rem_sh = {rem_q, acc_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

endmodule

@@ src/pst_back.sv @@
module pst_back import pst_pkg::*; #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  pst_job_t   pop_data_i,
  output logic       pop_ready_o,
  pst_res_if.source  res_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_JOBS);
  localparam int unsigned CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int unsigned WAIT_W = (BURST_W + CNT_W > TIME_W) ? BURST_W + CNT_W : TIME_W;
  localparam int unsigned TOT_W  = BURST_W + 2 * CNT_W;
  localparam int unsigned DVD_W  = TOT_W + FRAC_W;
  localparam int unsigned QX_W   = (DVD_W > AVG_W) ? DVD_W : AVG_W;
  localparam int unsigned IXX_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  logic [BURST_W-1:0] burst_mem [MAX_JOBS];
  logic [PRIO_W-1:0]  prio_mem  [MAX_JOBS];

  pst_back_state_e state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d, scan_q, scan_d, k_q, k_d;
  logic             drop_q, drop_d;
  logic             rd_vld_q, rd_vld_d;
  logic             have_prev_q, have_prev_d, have_best_q, have_best_d;
  logic             out_vld_q, out_vld_d;

  logic [IDX_W-1:0]   rd_addr_q, best_addr_q, best_addr_d, prev_addr_q, prev_addr_d;
  logic [BURST_W-1:0] rd_burst_q, best_burst_q, best_burst_d;
  logic [PRIO_W-1:0]  rd_prio_q, best_prio_q, best_prio_d, prev_prio_q, prev_prio_d;
  logic [WAIT_W-1:0]  wait_q, wait_d, turn;
  logic [TOT_W-1:0]   tw_q, tw_d, tt_q, tt_d, tw_new, tt_new;

  logic [INDEX_W-1:0] o_index_q, o_index_d;
  logic [BURST_W-1:0] o_burst_q, o_burst_d;
  logic [PRIO_W-1:0]  o_prio_q, o_prio_d;
  logic [TIME_W-1:0]  o_wait_q, o_wait_d, o_turn_q, o_turn_d;
  logic [AVG_W-1:0]   o_avgw_q, o_avgw_d, o_avgt_q, o_avgt_d;
  logic               o_final_q, o_final_d, o_ovf_q, o_ovf_d;

  logic               pop_fire, slot_free, div_start, divw_done, divt_done;
  logic [CNT_W-1:0]   n_new, n_m1;
  logic               gt_prev, lt_best;
  logic [IXX_W-1:0]   ix_ext;
  logic [DVD_W-1:0]   quot_w, quot_t;
  logic [QX_W-1:0]    qx_w, qx_t;

  assign pop_ready_o = (state_q == BK_LOAD);
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign slot_free   = !out_vld_q || res_o.ready;
  assign n_new       = n_q + CNT_W'(pop_data_i.keep);
  assign n_m1        = n_q - 1'b1;

  // The next job to serve is the smallest (priority, load position) above the last one served.
  assign gt_prev = !have_prev_q || (rd_prio_q > prev_prio_q) ||
                   ((rd_prio_q == prev_prio_q) && (rd_addr_q > prev_addr_q));
  assign lt_best = !have_best_q || (rd_prio_q < best_prio_q);

  assign turn   = wait_q + WAIT_W'(best_burst_q);
  assign tw_new = tw_q + TOT_W'(wait_q);
  assign tt_new = tt_q + TOT_W'(turn);
  assign ix_ext = IXX_W'(best_addr_q) + IXX_W'(1);
  assign qx_w   = QX_W'(quot_w);
  assign qx_t   = QX_W'(quot_t);

  always_ff @(posedge clk_i) begin
    if (pop_fire && pop_data_i.keep) begin
      burst_mem[n_q[IDX_W-1:0]] <= pop_data_i.burst_time;
      prio_mem[n_q[IDX_W-1:0]]  <= pop_data_i.priority_req;
    end
    rd_burst_q <= burst_mem[scan_q[IDX_W-1:0]];
    rd_prio_q  <= prio_mem[scan_q[IDX_W-1:0]];
  end

  pst_div #(.DVD_W(DVD_W), .DVS_W(CNT_W)) u_div_wait (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({tw_new, FRAC_W'(0)}),
    .divisor_i  (n_q),
    .done_o     (divw_done),
    .quot_o     (quot_w)
  );

  pst_div #(.DVD_W(DVD_W), .DVS_W(CNT_W)) u_div_turn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({tt_new, FRAC_W'(0)}),
    .divisor_i  (n_q),
    .done_o     (divt_done),
    .quot_o     (quot_t)
  );

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    drop_d       = drop_q;
    scan_d       = scan_q;
    k_d          = k_q;
    rd_vld_d     = (state_q == BK_SCAN) && (scan_q < n_q);
    have_prev_d  = have_prev_q;
    have_best_d  = have_best_q;
    best_addr_d  = best_addr_q;
    best_burst_d = best_burst_q;
    best_prio_d  = best_prio_q;
    prev_addr_d  = prev_addr_q;
    prev_prio_d  = prev_prio_q;
    wait_d       = wait_q;
    tw_d         = tw_q;
    tt_d         = tt_q;
    div_start    = 1'b0;
    out_vld_d    = out_vld_q && !res_o.ready;
    o_index_d    = o_index_q;
    o_burst_d    = o_burst_q;
    o_prio_d     = o_prio_q;
    o_wait_d     = o_wait_q;
    o_turn_d     = o_turn_q;
    o_avgw_d     = o_avgw_q;
    o_avgt_d     = o_avgt_q;
    o_final_d    = o_final_q;
    o_ovf_d      = o_ovf_q;

    unique case (state_q)
      BK_LOAD: begin
        if (pop_fire) begin
          n_d = n_new;
          if (!pop_data_i.keep) begin
            drop_d = 1'b1;
          end
          if (pop_data_i.last) begin
            if (n_new == '0) begin
              drop_d = 1'b0;
            end else begin
              state_d     = BK_SCAN;
              scan_d      = '0;
              k_d         = '0;
              have_prev_d = 1'b0;
              have_best_d = 1'b0;
              wait_d      = '0;
              tw_d        = '0;
              tt_d        = '0;
            end
          end
        end
      end
      BK_SCAN: begin
        if (scan_q < n_q) begin
          scan_d = scan_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (gt_prev && lt_best) begin
            have_best_d  = 1'b1;
            best_addr_d  = rd_addr_q;
            best_burst_d = rd_burst_q;
            best_prio_d  = rd_prio_q;
          end
          if (rd_addr_q == n_m1[IDX_W-1:0]) begin
            state_d = BK_EMIT;
          end
        end
      end
      BK_EMIT: begin
        if (k_q == n_m1) begin
          tw_d      = tw_new;
          tt_d      = tt_new;
          div_start = 1'b1;
          state_d   = BK_DIV;
        end else if (slot_free) begin
          out_vld_d   = 1'b1;
          o_index_d   = ix_ext[INDEX_W-1:0];
          o_burst_d   = best_burst_q;
          o_prio_d    = best_prio_q;
          o_wait_d    = wait_q[TIME_W-1:0];
          o_turn_d    = turn[TIME_W-1:0];
          o_avgw_d    = '0;
          o_avgt_d    = '0;
          o_final_d   = 1'b0;
          o_ovf_d     = drop_q;
          tw_d        = tw_new;
          tt_d        = tt_new;
          wait_d      = turn;
          k_d         = k_q + 1'b1;
          prev_addr_d = best_addr_q;
          prev_prio_d = best_prio_q;
          have_prev_d = 1'b1;
          have_best_d = 1'b0;
          scan_d      = '0;
          state_d     = BK_SCAN;
        end
      end
      BK_DIV: begin
        if (divw_done && divt_done) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        if (slot_free) begin
          out_vld_d = 1'b1;
          o_index_d = ix_ext[INDEX_W-1:0];
          o_burst_d = best_burst_q;
          o_prio_d  = best_prio_q;
          o_wait_d  = wait_q[TIME_W-1:0];
          o_turn_d  = turn[TIME_W-1:0];
          o_avgw_d  = qx_w[AVG_W-1:0];
          o_avgt_d  = qx_t[AVG_W-1:0];
          o_final_d = 1'b1;
          o_ovf_d   = drop_q;
          n_d       = '0;
          drop_d    = 1'b0;
          state_d   = BK_LOAD;
        end
      end
      default: begin
        state_d = BK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_LOAD;
      n_q         <= '0;
      drop_q      <= 1'b0;
      scan_q      <= '0;
      k_q         <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      have_best_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      drop_q      <= drop_d;
      scan_q      <= scan_d;
      k_q         <= k_d;
      rd_vld_q    <= rd_vld_d;
      have_prev_q <= have_prev_d;
      have_best_q <= have_best_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q    <= scan_q[IDX_W-1:0];
    best_addr_q  <= best_addr_d;
    best_burst_q <= best_burst_d;
    best_prio_q  <= best_prio_d;
    prev_addr_q  <= prev_addr_d;
    prev_prio_q  <= prev_prio_d;
    wait_q       <= wait_d;
    tw_q         <= tw_d;
    tt_q         <= tt_d;
    o_index_q    <= o_index_d;
    o_burst_q    <= o_burst_d;
    o_prio_q     <= o_prio_d;
    o_wait_q     <= o_wait_d;
    o_turn_q     <= o_turn_d;
    o_avgw_q     <= o_avgw_d;
    o_avgt_q     <= o_avgt_d;
    o_final_q    <= o_final_d;
    o_ovf_q      <= o_ovf_d;
  end

  assign res_o.valid             = out_vld_q;
  assign res_o.job_index         = o_index_q;
  assign res_o.job_burst         = o_burst_q;
  assign res_o.job_priority      = o_prio_q;
  assign res_o.wait_time         = o_wait_q;
  assign res_o.turnaround_time   = o_turn_q;
  assign res_o.avg_wait_q8       = o_avgw_q;
  assign res_o.avg_turnaround_q8 = o_avgt_q;
  assign res_o.final_res         = o_final_q;
  assign res_o.overflow          = o_ovf_q;

endmodule

@@ src/priority_schedule_timing.sv @@
// Channel  Dir  Payload                                                 Accepted when
// job_i    in   burst_time, priority_req, last                          valid && ready
// res_o    out  job_index, job_burst, job_priority, wait_time,          valid && ready
//               turnaround_time, avg_wait_q8, avg_turnaround_q8,
//               final_res, overflow
//
// Requests are loaded at one per cycle, while the back end is in its load state,
// through a two-entry queue into the job store. After the last request of a set,
// each result is found by one pass over the job store and is then emitted.
// The final result also waits for the two bit-serial averaging dividers.
// Reset clears all control state; the store needs none.
// Either side may stall at any time; the queue and the output register decouple them.
module priority_schedule_timing import pst_pkg::*; #(
  parameter int unsigned MAX_JOBS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pst_job_if.sink   job_i,
  pst_res_if.source res_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  pst_job_t push_data, pop_data;

  pst_front #(.MAX_JOBS(MAX_JOBS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  pst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  pst_back #(.MAX_JOBS(MAX_JOBS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule
